// ===== sv/sliding_window_retransmit_sender_core_defines.svh =====
// Assertion macros for the sliding window sender core
`ifndef SLIDING_WINDOW_RETRANSMIT_SENDER_CORE_DEFINES_SVH
`define SLIDING_WINDOW_RETRANSMIT_SENDER_CORE_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define SWRS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define SWRS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/swrs_pkg.sv =====
// Types, constants and helpers of the sliding window sender core
package swrs_pkg;

    localparam int WINDOW = 8;
    localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam logic [15:0] WIN16 = 16'(WINDOW);
    localparam logic [15:0] MOD_MUL = 16'((1 << 16) / WINDOW);

    typedef logic [IW-1:0] t_idx;
    localparam t_idx LAST_IDX = t_idx'(WINDOW - 1);

    typedef logic [1:0] t_cfg_addr;

    typedef enum logic [1:0] {
        CFG_TOTAL_PACKETS = 2'd0,
        CFG_DUP_LIMIT     = 2'd1,
        CFG_TIMEOUT_TICKS = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_ACK   = 2'd1,
        CMD_TICK  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        RSN_NEW     = 2'd0,
        RSN_FAST    = 2'd1,
        RSN_TIMEOUT = 2'd2
    } t_reason;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_AK_Q,
        ST_AK_R,
        ST_AK_RN,
        ST_AK_EVAL,
        ST_AK_WR,
        ST_SC_FIRST,
        ST_SC_RUN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] ack_num;
    } t_item;

    typedef struct packed {
        logic        send_valid;
        logic [15:0] send_seq;
        logic [2:0]  send_slot;
        logic [1:0]  send_reason;
        logic        window_empty;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [15:0] seq;
        logic [2:0]  dup;
        logic [15:0] sent_time;
    } t_entry;

    function automatic logic [2:0] slot3(input t_idx idx);
        logic [IW+2:0] wide;
        wide = {3'b000, idx};
        return wide[2:0];
    endfunction

endpackage

// ===== sv/sliding_window_retransmit_sender_core.sv =====
// Sliding window sender core: slot memory, ack handling and timeout scan
//
//  channel  | handshake              | word
//  ---------+------------------------+--------------------------------------
//  item in  | i_start, o_busy        | i_item   (command, ack_num)
//  result   | o_result_vld (strobe)  | o_result (send fields, empty, last)
//  config   | i_cfg_we               | i_cfg_idx, i_cfg_wdata
//
//  One item at a time; o_busy is high from acceptance until the last word.
//  Fill and scan touch one slot a cycle; an ack first reckons its slot as a
//  quotient and a remainder, then does two reads and two write-backs and
//  ends with the timeout scan.
//  Result words are strobed for one cycle each; the receiver cannot stall.
//  i_rst_n is synchronous; slots read as empty after reset, no clearing pass.
`include "sliding_window_retransmit_sender_core_defines.svh"

module sliding_window_retransmit_sender_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  swrs_pkg::t_item     i_item,
    output logic                o_busy,
    output logic                o_result_vld,
    output swrs_pkg::t_result   o_result,
    input  logic                i_cfg_we,
    input  swrs_pkg::t_cfg_addr i_cfg_idx,
    input  logic [15:0]         i_cfg_wdata
);
    import swrs_pkg::*;

    t_entry        r_mem [WINDOW];
    t_entry        r_rdata;
    t_idx          r_raddr_q;

    t_state        r_state, n_state;
    t_idx          r_cnt, n_cnt;
    t_idx          r_idx, n_idx;
    t_idx          r_nxt, n_nxt;
    logic [15:0]   r_x, n_x;
    logic [15:0]   r_q, n_q;
    logic [15:0]   r_ack, n_ack;
    logic          r_match, n_match;
    t_entry        r_e_idx, n_e_idx;
    logic [15:0]   r_next_seq, n_next_seq;
    logic [15:0]   r_now, n_now;
    logic [WINDOW-1:0] r_occ, n_occ;
    logic [WINDOW-1:0] r_init, n_init;
    logic          r_empty, n_empty;
    t_result       r_pend, n_pend;
    logic          r_pend_vld, n_pend_vld;
    t_result       r_out, n_out;
    logic          r_out_vld, n_out_vld;

    logic [15:0]   r_total;
    logic [2:0]    r_dup_limit;
    logic [15:0]   r_timeout;

    t_idx          w_raddr;
    logic          w_we;
    t_idx          w_waddr;
    t_entry        w_wdata;
    t_entry        w_eff;
    logic          w_found;
    t_result       w_found_res;
    logic          w_fill;
    logic [2:0]    w_dup_b;
    logic [31:0]   w_prod;
    logic [15:0]   w_rem;
    logic [15:0]   w_rem_c;
    logic [IW:0]   w_nxt_w;
    logic [15:0]   w_elapsed;

    assign w_eff = r_init[r_raddr_q] ? r_rdata : '0;
    assign w_fill = (r_next_seq != 16'd0) && (r_next_seq <= r_total);
    assign w_dup_b = (w_eff.dup == 3'd7) ? 3'd7 : w_eff.dup + 3'd1;
    assign w_prod = 32'(r_x) * 32'(MOD_MUL);
    assign w_rem = r_x - 16'(32'(r_q) * 32'(WINDOW));
    assign w_rem_c = (w_rem >= WIN16) ? w_rem - WIN16 : w_rem;
    assign w_nxt_w = {1'b0, t_idx'(w_rem_c)} + (IW+1)'(1);
    assign w_elapsed = r_now - w_eff.sent_time;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata   <= r_mem[w_raddr];
        r_raddr_q <= w_raddr;
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_idx      = r_idx;
        n_nxt      = r_nxt;
        n_x        = r_x;
        n_q        = r_q;
        n_ack      = r_ack;
        n_match    = r_match;
        n_e_idx    = r_e_idx;
        n_next_seq = r_next_seq;
        n_now      = r_now;
        n_occ      = r_occ;
        n_init     = r_init;
        n_empty    = r_empty;
        n_pend     = r_pend;
        n_pend_vld = r_pend_vld;
        n_out      = r_out;
        n_out_vld  = 1'b0;
        w_raddr    = r_cnt;
        w_we       = 1'b0;
        w_waddr    = r_cnt;
        w_wdata    = w_eff;
        w_found    = 1'b0;
        w_found_res = '0;

        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    case (i_item.command)
                        CMD_START: begin
                            n_next_seq = 16'd1;
                            n_cnt      = '0;
                            n_empty    = (r_total == 16'd0);
                            n_state    = ST_FILL;
                        end
                        CMD_ACK: begin
                            n_x     = i_item.ack_num - 16'd1;
                            n_ack   = i_item.ack_num;
                            n_state = ST_AK_Q;
                        end
                        CMD_TICK: begin
                            n_now   = r_now + 16'd1;
                            n_empty = (r_occ == '0);
                            n_state = ST_SC_FIRST;
                        end
                        default: begin
                            n_empty = (r_occ == '0);
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_FILL: begin
                w_we          = 1'b1;
                w_waddr       = r_cnt;
                w_wdata       = '{seq: r_next_seq, dup: 3'd0, sent_time: r_now};
                n_init[r_cnt] = 1'b1;
                n_occ[r_cnt]  = w_fill;
                if (w_fill) begin
                    n_next_seq  = r_next_seq + 16'd1;
                    w_found     = 1'b1;
                    w_found_res = '{send_valid: 1'b1, send_seq: r_next_seq,
                                    send_slot: slot3(r_cnt), send_reason: RSN_NEW,
                                    window_empty: 1'b0, last: 1'b0};
                end
                if (r_cnt == LAST_IDX) begin
                    n_state = ST_DONE;
                end else begin
                    n_cnt = r_cnt + t_idx'(1);
                end
            end
            ST_AK_Q: begin
                n_q     = w_prod[31:16];
                n_state = ST_AK_R;
            end
            ST_AK_R: begin
                n_idx   = t_idx'(w_rem_c);
                n_nxt   = (w_nxt_w == (IW+1)'(WINDOW)) ? '0 : t_idx'(w_nxt_w);
                w_raddr = t_idx'(w_rem_c);
                n_state = ST_AK_RN;
            end
            ST_AK_RN: begin
                w_raddr = r_nxt;
                n_e_idx = w_eff;
                n_match = r_occ[r_idx] && (w_eff.seq == r_ack);
                n_state = ST_AK_EVAL;
            end
            ST_AK_EVAL: begin
                w_we          = 1'b1;
                w_waddr       = r_nxt;
                w_wdata       = w_eff;
                w_wdata.dup   = w_dup_b;
                n_init[r_nxt] = 1'b1;
                if (r_match) begin
                    n_occ[r_idx] = w_fill;
                    if (w_fill) begin
                        n_e_idx.seq = r_next_seq;
                        n_next_seq  = r_next_seq + 16'd1;
                        w_found     = 1'b1;
                        w_found_res = '{send_valid: 1'b1, send_seq: r_next_seq,
                                        send_slot: slot3(r_idx), send_reason: RSN_NEW,
                                        window_empty: 1'b0, last: 1'b0};
                    end
                end else if (w_dup_b == r_dup_limit) begin
                    w_wdata.dup = 3'd0;
                    if (r_occ[r_nxt]) begin
                        w_wdata.sent_time = r_now;
                        w_found     = 1'b1;
                        w_found_res = '{send_valid: 1'b1, send_seq: w_eff.seq,
                                        send_slot: slot3(r_nxt), send_reason: RSN_FAST,
                                        window_empty: 1'b0, last: 1'b0};
                    end
                end
                n_empty = (n_occ == '0);
                n_state = ST_AK_WR;
            end
            ST_AK_WR: begin
                w_we    = r_match && r_occ[r_idx];
                w_waddr = r_idx;
                w_wdata = '{seq: r_e_idx.seq, dup: r_e_idx.dup, sent_time: r_now};
                n_state = ST_SC_FIRST;
            end
            ST_SC_FIRST: begin
                w_raddr = '0;
                n_cnt   = '0;
                n_state = ST_SC_RUN;
            end
            ST_SC_RUN: begin
                w_raddr = (r_cnt == LAST_IDX) ? r_cnt : r_cnt + t_idx'(1);
                if (r_occ[r_cnt] && (w_elapsed >= r_timeout)) begin
                    w_we          = 1'b1;
                    w_waddr       = r_cnt;
                    w_wdata       = '{seq: w_eff.seq, dup: 3'd0, sent_time: r_now};
                    n_init[r_cnt] = 1'b1;
                    w_found       = 1'b1;
                    w_found_res   = '{send_valid: 1'b1, send_seq: w_eff.seq,
                                      send_slot: slot3(r_cnt), send_reason: RSN_TIMEOUT,
                                      window_empty: 1'b0, last: 1'b0};
                end
                if (r_cnt == LAST_IDX) begin
                    n_state = ST_DONE;
                end else begin
                    n_cnt = r_cnt + t_idx'(1);
                end
            end
            ST_DONE: begin
                n_out_vld        = 1'b1;
                n_out            = r_pend_vld ? r_pend : '0;
                n_out.window_empty = r_empty;
                n_out.last       = 1'b1;
                n_pend_vld       = 1'b0;
                n_state          = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // hold one word back so the final one can carry last
        if (w_found) begin
            if (r_pend_vld) begin
                n_out_vld          = 1'b1;
                n_out              = r_pend;
                n_out.window_empty = r_empty;
                n_out.last         = 1'b0;
            end
            n_pend     = w_found_res;
            n_pend_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_next_seq  <= 16'd1;
            r_now       <= 16'd0;
            r_occ       <= '0;
            r_init      <= '0;
            r_pend_vld  <= 1'b0;
            r_out_vld   <= 1'b0;
            r_total     <= 16'd0;
            r_dup_limit <= 3'd3;
            r_timeout   <= 16'd3;
        end else begin
            r_state    <= n_state;
            r_next_seq <= n_next_seq;
            r_now      <= n_now;
            r_occ      <= n_occ;
            r_init     <= n_init;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TOTAL_PACKETS: r_total     <= i_cfg_wdata;
                    CFG_DUP_LIMIT:     r_dup_limit <= i_cfg_wdata[2:0];
                    CFG_TIMEOUT_TICKS: r_timeout   <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt   <= n_cnt;
        r_idx   <= n_idx;
        r_nxt   <= n_nxt;
        r_x     <= n_x;
        r_q     <= n_q;
        r_ack   <= n_ack;
        r_match <= n_match;
        r_e_idx <= n_e_idx;
        r_empty <= n_empty;
        r_pend  <= n_pend;
        r_out   <= n_out;
    end

    assign o_busy       = (r_state != ST_IDLE);
    assign o_result_vld = r_out_vld;
    assign o_result     = r_out;

    `SWRS_ASSERT_NEXT(a_accept_busy, i_start && !o_busy, o_busy,
        "accepted item did not raise busy")
    `SWRS_ASSERT_NOW(a_last_idle, r_out_vld && r_out.last, r_state == ST_IDLE,
        "last word delivered while item still in progress")
    `SWRS_ASSERT_NOW(a_nosend_last, r_out_vld && !r_out.send_valid, r_out.last,
        "word without a send is not the only word of its item")
    `SWRS_ASSERT_NOW(a_empty_match, r_out_vld && r_out.last,
        r_out.window_empty == (r_occ == '0), "window_empty disagrees with slot occupancy")

endmodule
